@@ rtl/vlr3d_pkg.sv @@
`default_nettype none
package vlr3d_pkg;

  localparam int COORD_W   = 6;
  localparam int TYPE_W    = 8;
  localparam int ADDR_W    = 15;
  localparam int GRID_W    = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W     = 6;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int D2_W      = COORD_W + 1;
  localparam int ERR_W     = D2_W + 2;
  localparam int MAX_DIM_DEF = 32;
  localparam logic [GRID_W-1:0] GRID_RST = GRID_W'(32);

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL1 = 3'b010,
    ST_MUL2 = 3'b100
  } state_t;

endpackage
`default_nettype wire

@@ rtl/voxel_line_rasterizer_3d.sv @@
`default_nettype none
// channel   direction  ports                                      handshake
// in_       in         start_x/y/z, end_x/y/z, fill_type          in_valid / in_ready
// out_      out        cell_x/y/z, cell_address, cell_type,       out_valid / out_ready
//                      outside, last
// cfg_      in         cfg_we, cfg_index, cfg_wdata               write on cfg_we, no wait
//
// for a line of n dominant-axis steps, each voxel makes two passes through the
// one shared multiplier
// reset (rst_n low, synchronous) idles the walker, empties the output register
// and sets both grid extents to 32
// out_ready low holds the walker in its address pass; the input side takes a new
// line as soon as the walker is idle, even while the last voxel still waits
module voxel_line_rasterizer_3d #(
  parameter int MAX_DIM = vlr3d_pkg::MAX_DIM_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // line requests
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  signed [vlr3d_pkg::COORD_W-1:0] in_start_x,
  input  wire  signed [vlr3d_pkg::COORD_W-1:0] in_start_y,
  input  wire  signed [vlr3d_pkg::COORD_W-1:0] in_start_z,
  input  wire  signed [vlr3d_pkg::COORD_W-1:0] in_end_x,
  input  wire  signed [vlr3d_pkg::COORD_W-1:0] in_end_y,
  input  wire  signed [vlr3d_pkg::COORD_W-1:0] in_end_z,
  input  wire         [vlr3d_pkg::TYPE_W-1:0]  in_fill_type,
  // voxel results
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [vlr3d_pkg::COORD_W-1:0] out_cell_x,
  output logic signed [vlr3d_pkg::COORD_W-1:0] out_cell_y,
  output logic signed [vlr3d_pkg::COORD_W-1:0] out_cell_z,
  output logic        [vlr3d_pkg::ADDR_W-1:0]  out_cell_address,
  output logic        [vlr3d_pkg::TYPE_W-1:0]  out_cell_type,
  output logic                                 out_outside,
  output logic                                 out_last,
  // configuration writes
  input  wire                                  cfg_we,
  input  wire         [vlr3d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire         [vlr3d_pkg::GRID_W-1:0]  cfg_wdata
);
  import vlr3d_pkg::*;

  // extent after saturation to MAX_DIM
  localparam int EXT_W  = $clog2(MAX_DIM + 1);
  localparam int MULT_W = ADDR_W + EXT_W;

  // configuration
  logic [GRID_W-1:0] grid_width_r, grid_height_r;
  logic [EXT_W-1:0]  w_ext, h_ext;

  // walker state
  state_t               state_r, state_nxt;
  logic [COORD_W-1:0]   p_r   [3];
  logic [COORD_W-1:0]   p_nxt [3];
  logic [ERR_W-1:0]     err_r   [3];
  logic [ERR_W-1:0]     err_nxt [3];
  logic [D2_W-1:0]      d2_r  [3];
  logic [2:0]           neg_r;
  logic [2:0]           dom_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TYPE_W-1:0]    type_r;
  logic [ADDR_W-1:0]    prod_r;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0]   ox_r, oy_r, oz_r;
  logic [ADDR_W-1:0]    oaddr_r;
  logic [TYPE_W-1:0]    otype_r;
  logic                 oout_r, olast_r;

  // line setup from the request
  logic [COORD_W-1:0]   st [3];
  logic [COORD_W-1:0]   en [3];
  logic [DIFF_W-1:0]    dif [3];
  logic [COORD_W-1:0]   ad  [3];
  logic [2:0]           dom_in;
  logic [CNT_W-1:0]     n_in;

  // shared multiplier
  logic [ADDR_W-1:0]    mul_a;
  logic [EXT_W-1:0]     mul_b;
  logic [MULT_W-1:0]    mul_p;

  // per-voxel evaluation
  logic                 cur_outside, cur_last, emit_go;
  logic [ADDR_W-1:0]    cur_addr;
  logic [D2_W-1:0]      d2_dom;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_RST;
      grid_height_r <= GRID_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_ext = (int'(grid_width_r) > MAX_DIM) ? EXT_W'(MAX_DIM) : EXT_W'(grid_width_r);
    h_ext = (int'(grid_height_r) > MAX_DIM) ? EXT_W'(MAX_DIM) : EXT_W'(grid_height_r);
  end

  // deltas, absolute extents and dominant axis (ties go to x, then y)
  always_comb begin
    st[0] = in_start_x;  st[1] = in_start_y;  st[2] = in_start_z;
    en[0] = in_end_x;    en[1] = in_end_y;    en[2] = in_end_z;
    for (int i = 0; i < 3; i++) begin
      dif[i] = {en[i][COORD_W-1], en[i]} - {st[i][COORD_W-1], st[i]};
      ad[i]  = dif[i][DIFF_W-1] ? COORD_W'(-dif[i]) : dif[i][COORD_W-1:0];
    end
    if (ad[0] >= ad[1] && ad[0] >= ad[2]) begin
      dom_in = 3'b001;
      n_in   = ad[0];
    end else if (ad[1] >= ad[2]) begin
      dom_in = 3'b010;
      n_in   = ad[1];
    end else begin
      dom_in = 3'b100;
      n_in   = ad[2];
    end
  end

  // first pass z*height, second pass width*(y + z*height)
  always_comb begin
    if (state_r == ST_MUL1) begin
      mul_a = ADDR_W'(p_r[2][COORD_W-2:0]);
      mul_b = h_ext;
    end else begin
      mul_a = ADDR_W'(p_r[1][COORD_W-2:0]) + prod_r;
      mul_b = w_ext;
    end
    mul_p = MULT_W'(mul_a) * MULT_W'(mul_b);
  end

  always_comb begin
    cur_outside = 1'b0;
    if (p_r[0][COORD_W-1] || 8'(p_r[0][COORD_W-2:0]) >= 8'(w_ext)) cur_outside = 1'b1;
    if (p_r[1][COORD_W-1] || 8'(p_r[1][COORD_W-2:0]) >= 8'(h_ext)) cur_outside = 1'b1;
    if (p_r[2][COORD_W-1] || 8'(p_r[2][COORD_W-2:0]) >= 8'(w_ext)) cur_outside = 1'b1;
    cur_addr = cur_outside ? '0 :
               ADDR_W'(p_r[0][COORD_W-2:0]) + mul_p[ADDR_W-1:0];
    cur_last = cur_outside || (cnt_r == '0);
    d2_dom   = (dom_r[0] ? d2_r[0] : '0) | (dom_r[1] ? d2_r[1] : '0) |
               (dom_r[2] ? d2_r[2] : '0);
  end

  // voxel is loaded into the output register once that register is free
  assign emit_go = (state_r == ST_MUL2) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    for (int i = 0; i < 3; i++) begin
      p_nxt[i]   = p_r[i];
      err_nxt[i] = err_r[i];
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          if (cur_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MUL1;
            cnt_nxt   = cnt_r - CNT_W'(1);
            // bresenham step: dominant axis always moves, the others when
            // their error term is positive
            for (int i = 0; i < 3; i++) begin
              if (dom_r[i]) begin
                p_nxt[i] = neg_r[i] ? p_r[i] - COORD_W'(1) : p_r[i] + COORD_W'(1);
              end else if (!err_r[i][ERR_W-1] && err_r[i] != '0) begin
                p_nxt[i]   = neg_r[i] ? p_r[i] - COORD_W'(1) : p_r[i] + COORD_W'(1);
                err_nxt[i] = err_r[i] - ERR_W'(d2_dom) + ERR_W'(d2_r[i]);
              end else begin
                err_nxt[i] = err_r[i] + ERR_W'(d2_r[i]);
              end
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      // line setup
      for (int i = 0; i < 3; i++) begin
        p_r[i]   <= st[i];
        d2_r[i]  <= {ad[i], 1'b0};
        err_r[i] <= ERR_W'({ad[i], 1'b0}) - ERR_W'(n_in);
        neg_r[i] <= dif[i][DIFF_W-1];
      end
      dom_r  <= dom_in;
      cnt_r  <= n_in;
      type_r <= in_fill_type;
    end else begin
      for (int i = 0; i < 3; i++) begin
        p_r[i]   <= p_nxt[i];
        err_r[i] <= err_nxt[i];
      end
      cnt_r <= cnt_nxt;
    end
    if (state_r == ST_MUL1) prod_r <= mul_p[ADDR_W-1:0];
    if (emit_go) begin
      ox_r    <= p_r[0];
      oy_r    <= p_r[1];
      oz_r    <= p_r[2];
      oaddr_r <= cur_addr;
      otype_r <= type_r;
      oout_r  <= cur_outside;
      olast_r <= cur_last;
    end
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_cell_x       = ox_r;
  assign out_cell_y       = oy_r;
  assign out_cell_z       = oz_r;
  assign out_cell_address = oaddr_r;
  assign out_cell_type    = otype_r;
  assign out_outside      = oout_r;
  assign out_last         = olast_r;

endmodule
`default_nettype wire
